[rtl/core/u16cim_pkg.sv]
// Shared constants, types and helpers for the UTF-16 composition index mapper.
`timescale 1ns / 1ps

package u16cim_pkg;

    // Largest number of code units kept per composition; more saturate.
    localparam int MAX_UNITS = 256;
    localparam int CNT_W     = $clog2(MAX_UNITS + 1);

    // Fixed field widths of the interface.
    localparam int UNIT_W    = 16;
    localparam int ATTR_W    = 8;
    localparam int CARET_W   = 9;
    localparam int POINT_W   = 9;
    localparam int SEL_END_W = 8;
    localparam int CFG_IDX_W = 1;

    // Common width for comparing counters against the caret and output fields.
    localparam int EXT_W = (CNT_W > CARET_W) ? CNT_W : CARET_W;

    // Surrogate ranges.
    localparam logic [UNIT_W-1:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_SURR_LAST   = 16'hDFFF;

    // Target run tracking.
    localparam logic [1:0] RUN_NONE = 2'd0;
    localparam logic [1:0] RUN_OPEN = 2'd1;
    localparam logic [1:0] RUN_DONE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_B = 1'b1;

    localparam logic [ATTR_W-1:0] TARGET_A_RESET = 8'd1;
    localparam logic [ATTR_W-1:0] TARGET_B_RESET = 8'd3;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic [ATTR_W-1:0]  attr;
        logic               attr_valid;
        logic [CARET_W-1:0] caret;
        logic               has_unit;
        logic               is_last;
    } t_item;

    typedef struct packed {
        logic [POINT_W-1:0]   code_point_count;
        logic [POINT_W-1:0]   caret_point;
        logic                 sel_found;
        logic [POINT_W-1:0]   sel_begin;
        logic [SEL_END_W-1:0] sel_end;
        logic                 overflow;
    } t_result;

    typedef struct packed {
        logic [ATTR_W-1:0] target_a;
        logic [ATTR_W-1:0] target_b;
    } t_cfg;

    function automatic logic [EXT_W-1:0] ext_cnt(input logic [CNT_W-1:0] v);
        return EXT_W'(v);
    endfunction

    function automatic logic [EXT_W-1:0] ext_caret(input logic [CARET_W-1:0] v);
        return EXT_W'(v);
    endfunction

endpackage

[rtl/core/u16cim_in_reg.sv]
// Input register stage: holds one request for the tracking logic.
`timescale 1ns / 1ps

module u16cim_in_reg import u16cim_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_adv,
    output logic  o_item_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held request moves on this cycle.
    assign o_ready      = !r_valid || i_adv;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/core/u16cim_track.sv]
// Per-composition running state and the result computed from it.
`timescale 1ns / 1ps

module u16cim_track import u16cim_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_adv,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [CNT_W-1:0]   r_unit_count, n_unit_count;
    logic [CNT_W-1:0]   r_points, n_points;
    logic               r_pending, n_pending;
    logic [CARET_W-1:0] r_caret, n_caret;
    logic [CNT_W-1:0]   r_pbc, n_pbc;
    logic [1:0]         r_phase, n_phase;
    logic [CNT_W-1:0]   r_run_start, n_run_start;
    logic [CNT_W-1:0]   r_run_end, n_run_end;
    logic               r_ovf, n_ovf;

    logic               take;
    logic               is_high;
    logic               is_low;
    logic               target;
    logic [CNT_W-1:0]   idx;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   cursor;
    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   sel_s;
    logic [CNT_W-1:0]   sel_e;
    logic [EXT_W-1:0]   total_x;
    logic [EXT_W-1:0]   cursor_x;
    logic [EXT_W-1:0]   sel_s_x;
    logic [EXT_W-1:0]   sel_e_x;

    assign is_high = (i_item.code_unit >= HIGH_SURR_FIRST) &&
                     (i_item.code_unit <= HIGH_SURR_LAST);
    assign is_low  = (i_item.code_unit >= LOW_SURR_FIRST) &&
                     (i_item.code_unit <= LOW_SURR_LAST);
    assign target  = i_item.attr_valid &&
                     ((i_item.attr == i_cfg.target_a) || (i_item.attr == i_cfg.target_b));
    assign take    = i_item.has_unit && (r_unit_count < CNT_W'(MAX_UNITS));
    // A waiting high surrogate not completed by this unit closes as a lone point.
    assign idx     = (r_pending && !is_low) ? (r_points + CNT_W'(1)) : r_points;

    always_comb begin
        n_unit_count = r_unit_count;
        n_points     = r_points;
        n_pending    = r_pending;
        n_caret      = (r_unit_count == '0) ? i_item.caret : r_caret;
        n_pbc        = r_pbc;
        n_phase      = r_phase;
        n_run_start  = r_run_start;
        n_run_end    = r_run_end;
        n_ovf        = r_ovf | (i_item.has_unit && !take);

        if (take) begin
            if (r_pending && is_low) begin
                n_points  = r_points + CNT_W'(1);
                n_pending = 1'b0;
            end else begin
                n_points  = is_high ? idx : (idx + CNT_W'(1));
                n_pending = is_high;
            end

            if (ext_cnt(r_unit_count) == ext_caret(n_caret)) begin
                n_pbc = idx;
            end

            if (target) begin
                if (r_phase == RUN_NONE) begin
                    n_phase     = RUN_OPEN;
                    n_run_start = idx;
                    n_run_end   = idx;
                end else if (r_phase == RUN_OPEN) begin
                    n_run_end = idx;
                end
            end else if (r_phase == RUN_OPEN) begin
                n_phase = RUN_DONE;
            end

            n_unit_count = r_unit_count + CNT_W'(1);
        end
    end

    // Result view of the updated state; only used on the closing request.
    always_comb begin
        total  = n_points + CNT_W'(n_pending);
        cursor = (ext_caret(n_caret) >= ext_cnt(n_unit_count)) ? total : n_pbc;
        if (cursor > total) begin
            cursor = total;
        end
        cap   = (total == '0) ? '0 : (total - CNT_W'(1));
        sel_s = '0;
        sel_e = '0;
        if (n_phase != RUN_NONE) begin
            sel_s = n_run_start;
            sel_e = (n_run_end < n_run_start) ? n_run_start : n_run_end;
            if (sel_s > total) begin
                sel_s = total;
            end
            if (sel_e > cap) begin
                sel_e = cap;
            end
        end
    end

    assign total_x  = ext_cnt(total);
    assign cursor_x = ext_cnt(cursor);
    assign sel_s_x  = ext_cnt(sel_s);
    assign sel_e_x  = ext_cnt(sel_e);

    assign o_result.code_point_count = total_x[POINT_W-1:0];
    assign o_result.caret_point      = cursor_x[POINT_W-1:0];
    assign o_result.sel_found        = (n_phase != RUN_NONE);
    assign o_result.sel_begin        = sel_s_x[POINT_W-1:0];
    assign o_result.sel_end          = sel_e_x[SEL_END_W-1:0];
    assign o_result.overflow         = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_count <= '0;
            r_points     <= '0;
            r_pending    <= 1'b0;
            r_caret      <= '0;
            r_pbc        <= '0;
            r_phase      <= RUN_NONE;
            r_run_start  <= '0;
            r_run_end    <= '0;
            r_ovf        <= 1'b0;
        end else if (i_adv) begin
            if (i_item.is_last) begin
                r_unit_count <= '0;
                r_points     <= '0;
                r_pending    <= 1'b0;
                r_caret      <= '0;
                r_pbc        <= '0;
                r_phase      <= RUN_NONE;
                r_run_start  <= '0;
                r_run_end    <= '0;
                r_ovf        <= 1'b0;
            end else begin
                r_unit_count <= n_unit_count;
                r_points     <= n_points;
                r_pending    <= n_pending;
                r_caret      <= n_caret;
                r_pbc        <= n_pbc;
                r_phase      <= n_phase;
                r_run_start  <= n_run_start;
                r_run_end    <= n_run_end;
                r_ovf        <= n_ovf;
            end
        end
    end

endmodule

[rtl/core/u16cim_out_reg.sv]
// Output register stage: holds one result until the consumer takes it.
`timescale 1ns / 1ps

module u16cim_out_reg import u16cim_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[rtl/core/utf16_composition_index_mapper_unit.sv]
// Top level of the UTF-16 composition index mapper.
`timescale 1ns / 1ps

// Takes one UTF-16 code unit per request and, on the request flagged is_last,
// returns one result: code point count, caret as a code point index, the first
// run of target-attribute units as an inclusive code point range, and an
// overflow flag for compositions longer than MAX_UNITS units. Throughput is one
// request per clock unless a result is held waiting for i_ready: the running
// counters update with a single increment and compare per unit. A request is
// captured in the input register at its accepting edge; a closing request's
// result is then loaded into the output register, which raises o_valid. A
// non-final request never waits on the output side. While a finished result
// waits for i_ready, one closing request can still be taken into the input
// register; after that o_ready drops until the result register frees up. Target
// codes are written through i_cfg_we/i_cfg_idx/i_cfg_data and must only change
// while no request is in flight. State returns to its reset values after each result.

module utf16_composition_index_mapper_unit import u16cim_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ATTR_W-1:0]    i_cfg_data,
    // request channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [UNIT_W-1:0]    i_code_unit,
    input  logic [ATTR_W-1:0]    i_attr,
    input  logic                 i_attr_valid,
    input  logic [CARET_W-1:0]   i_caret,
    input  logic                 i_has_unit,
    input  logic                 i_is_last,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [POINT_W-1:0]   o_code_point_count,
    output logic [POINT_W-1:0]   o_caret_point,
    output logic                 o_sel_found,
    output logic [POINT_W-1:0]   o_sel_begin,
    output logic [SEL_END_W-1:0] o_sel_end,
    output logic                 o_overflow
);

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    adv;
    t_result calc_result;
    t_result out_result;

    // Target code registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_a <= TARGET_A_RESET;
            r_cfg.target_b <= TARGET_B_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_A: r_cfg.target_a <= i_cfg_data;
                CFG_TARGET_B: r_cfg.target_b <= i_cfg_data;
            endcase
        end
    end

    assign in_item.code_unit  = i_code_unit;
    assign in_item.attr       = i_attr;
    assign in_item.attr_valid = i_attr_valid;
    assign in_item.caret      = i_caret;
    assign in_item.has_unit   = i_has_unit;
    assign in_item.is_last    = i_is_last;

    // A held request retires this cycle unless it needs the result register
    // and that register is still occupied.
    assign adv = held_valid && (!held_item.is_last || out_free);

    u16cim_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .i_adv        (adv),
        .o_item_valid (held_valid),
        .o_item       (held_item)
    );

    u16cim_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (held_item),
        .i_adv    (adv),
        .i_cfg    (r_cfg),
        .o_result (calc_result)
    );

    u16cim_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv && held_item.is_last),
        .i_result (calc_result),
        .i_ready  (i_ready),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_code_point_count = out_result.code_point_count;
    assign o_caret_point      = out_result.caret_point;
    assign o_sel_found        = out_result.sel_found;
    assign o_sel_begin        = out_result.sel_begin;
    assign o_sel_end          = out_result.sel_end;
    assign o_overflow         = out_result.overflow;

endmodule

[rtl/core/u16cim_checker.sv]
// Port-level checks for the UTF-16 composition index mapper, bound to the top.
`timescale 1ns / 1ps

module u16cim_checker import u16cim_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [POINT_W-1:0]   o_code_point_count,
    input logic [POINT_W-1:0]   o_caret_point,
    input logic                 o_sel_found,
    input logic [POINT_W-1:0]   o_sel_begin,
    input logic [SEL_END_W-1:0] o_sel_end,
    input logic                 o_overflow
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_point_count) &&
        $stable(o_caret_point) && $stable(o_sel_found) &&
        $stable(o_sel_begin) && $stable(o_sel_end) && $stable(o_overflow))
        else $error("result changed while stalled");

    // No run found means an all-zero selection.
    a_no_sel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sel_found |-> o_sel_begin == '0 && o_sel_end == '0)
        else $error("selection fields set without selection");

    // Caret never maps past the total.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_caret_point <= o_code_point_count)
        else $error("cursor beyond code point count");

    // Selection lies inside the string and is ordered.
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sel_found |->
        POINT_W'(o_sel_end) < o_code_point_count &&
        o_sel_begin <= POINT_W'(o_sel_end))
        else $error("selection out of range");

endmodule

bind utf16_composition_index_mapper_unit u16cim_checker u_u16cim_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_code_point_count (o_code_point_count),
    .o_caret_point      (o_caret_point),
    .o_sel_found        (o_sel_found),
    .o_sel_begin        (o_sel_begin),
    .o_sel_end          (o_sel_end),
    .o_overflow         (o_overflow)
);

[bench/tb_top.sv]
// Self-checking bench for the UTF-16 composition index mapper.
`timescale 1ns / 1ps

// Requests go in through a clocked driver fed from a queue that the stimulus
// process fills. Each accepted request runs through a bench-side mapper that
// tracks code points, the caret and the first target run. Every closing
// request pushes the expected mapping. A clocked monitor pops one mapping per
// accepted result and compares it field by field.
// Target codes change only while the block is drained.

module tb_top;
    import u16cim_pkg::*;

    localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
    localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
    localparam int PHASE_ITEMS  = 190;   // requests per random phase
    localparam int SETTLE_TICKS = 4;     // covers the input register stage

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_TARGET_A;
    logic [ATTR_W-1:0]    i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [UNIT_W-1:0]    i_code_unit = '0;
    logic [ATTR_W-1:0]    i_attr = '0;
    logic                 i_attr_valid = 1'b0;
    logic [CARET_W-1:0]   i_caret = '0;
    logic                 i_has_unit = 1'b0;
    logic                 i_is_last = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [POINT_W-1:0]   o_code_point_count;
    logic [POINT_W-1:0]   o_caret_point;
    logic                 o_sel_found;
    logic [POINT_W-1:0]   o_sel_begin;
    logic [SEL_END_W-1:0] o_sel_end;
    logic                 o_overflow;

    utf16_composition_index_mapper_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_code_unit        (i_code_unit),
        .i_attr             (i_attr),
        .i_attr_valid       (i_attr_valid),
        .i_caret            (i_caret),
        .i_has_unit         (i_has_unit),
        .i_is_last          (i_is_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_code_point_count (o_code_point_count),
        .o_caret_point      (o_caret_point),
        .o_sel_found        (o_sel_found),
        .o_sel_begin        (o_sel_begin),
        .o_sel_end          (o_sel_end),
        .o_overflow         (o_overflow)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_item   pending_requests[$];   // built by stimulus, drained by driver
    t_result expected_mappings[$];  // pushed on closing requests
    int      queued_items = 0;
    int      failures = 0;
    int      tx_max_gap = 9;        // sender gap drawn per request, 0..max
    int      rx_max_stall = 9;      // receiver stall drawn per result
    bit      hold_ask = 1'b0;       // asks the monitor for a long hold-off

    // Bench copy of the target codes, kept in step with register writes.
    logic [ATTR_W-1:0] tgt_a = TARGET_A_RESET;
    logic [ATTR_W-1:0] tgt_b = TARGET_B_RESET;

    // Mapper state for the composition in progress.
    int         pm_units = 0;       // units taken (dropped ones excluded)
    int         pm_points = 0;      // code points known complete
    bit         pm_high_wait = 0;   // high surrogate awaiting its partner
    int         pm_caret = 0;       // latched caret, in units
    int         pm_caret_point = 0; // code point index of the unit at the caret
    logic [1:0] pm_run = RUN_NONE;
    int         pm_run_lo = 0;
    int         pm_run_hi = 0;
    bit         pm_dropped = 0;

    // Advance the mapper by one accepted request; a closing request yields
    // the expected mapping and clears the composition state.
    task automatic predict_mapping(input t_item req);
        int      idx;
        int      total;
        int      cursor;
        int      cap;
        int      sel_lo;
        int      sel_hi;
        bit      hi;
        bit      lo;
        bit      target;
        t_result res;
        // Caret is re-latched on every request until a unit is taken.
        if (pm_units == 0)
            pm_caret = req.caret;
        if (req.has_unit) begin
            if (pm_units < MAX_UNITS) begin
                hi = req.code_unit >= HIGH_SURR_FIRST && req.code_unit <= HIGH_SURR_LAST;
                lo = req.code_unit >= LOW_SURR_FIRST && req.code_unit <= LOW_SURR_LAST;
                if (pm_high_wait && lo) begin
                    // low half of a pair shares the pair's index
                    idx = pm_points;
                    pm_points++;
                    pm_high_wait = 0;
                end else begin
                    if (pm_high_wait) begin
                        // previous high surrogate turned out lone
                        pm_points++;
                        pm_high_wait = 0;
                    end
                    idx = pm_points;
                    if (hi)
                        pm_high_wait = 1;
                    else
                        pm_points++;
                end
                if (pm_units == pm_caret)
                    pm_caret_point = idx;
                target = req.attr_valid && (req.attr == tgt_a || req.attr == tgt_b);
                if (target) begin
                    if (pm_run == RUN_NONE) begin
                        pm_run = RUN_OPEN;
                        pm_run_lo = idx;
                        pm_run_hi = idx;
                    end else if (pm_run == RUN_OPEN) begin
                        pm_run_hi = idx;
                    end
                end else if (pm_run == RUN_OPEN) begin
                    pm_run = RUN_DONE;   // only the first run counts
                end
                pm_units++;
            end else begin
                pm_dropped = 1;
            end
        end
        if (req.is_last) begin
            total = pm_points + pm_high_wait;   // trailing high counts once
            cursor = (pm_caret >= pm_units) ? total : pm_caret_point;
            if (cursor > total)
                cursor = total;
            sel_lo = 0;
            sel_hi = 0;
            if (pm_run != RUN_NONE) begin
                cap = (total == 0) ? 0 : total - 1;
                sel_lo = pm_run_lo;
                sel_hi = (pm_run_hi < pm_run_lo) ? pm_run_lo : pm_run_hi;
                if (sel_lo > total)
                    sel_lo = total;
                if (sel_hi > cap)
                    sel_hi = cap;
            end
            res.code_point_count = POINT_W'(total);
            res.caret_point      = POINT_W'(cursor);
            res.sel_found        = pm_run != RUN_NONE;
            res.sel_begin        = POINT_W'(sel_lo);
            res.sel_end          = SEL_END_W'(sel_hi);
            res.overflow         = pm_dropped;
            expected_mappings.push_back(res);
            pm_units = 0;
            pm_points = 0;
            pm_high_wait = 0;
            pm_caret = 0;
            pm_caret_point = 0;
            pm_run = RUN_NONE;
            pm_run_lo = 0;
            pm_run_hi = 0;
            pm_dropped = 0;
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers one request at a time, with a drawn gap before each.
    // ------------------------------------------------------------------
    t_item offered_req;
    bit    holding_req = 1'b0;
    int    gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            holding_req = 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_mapping(offered_req);
                holding_req = 1'b0;
            end
            if (!holding_req && pending_requests.size() != 0) begin
                offered_req = pending_requests.pop_front();
                holding_req = 1'b1;
                gap_left = $urandom_range(0, tx_max_gap);
            end
            if (holding_req && gap_left == 0) begin
                // valid stays up with a stable payload until taken
                i_valid      <= 1'b1;
                i_code_unit  <= offered_req.code_unit;
                i_attr       <= offered_req.attr;
                i_attr_valid <= offered_req.attr_valid;
                i_caret      <= offered_req.caret;
                i_has_unit   <= offered_req.has_unit;
                i_is_last    <= offered_req.is_last;
            end else begin
                i_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: drawn stall before each result, plus an on-demand hold-off.
    // ------------------------------------------------------------------
    int      stall_left = 0;
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_mappings.size() == 0) begin
                    $error("result accepted with no mapping pending");
                    failures++;
                end else begin
                    want = expected_mappings.pop_front();
                    check_field("code_point_count", 16'(want.code_point_count),
                                16'(o_code_point_count));
                    check_field("caret_point", 16'(want.caret_point),
                                16'(o_caret_point));
                    check_field("sel_found", 16'(want.sel_found), 16'(o_sel_found));
                    check_field("sel_begin", 16'(want.sel_begin), 16'(o_sel_begin));
                    check_field("sel_end", 16'(want.sel_end), 16'(o_sel_end));
                    check_field("overflow", 16'(want.overflow), 16'(o_overflow));
                end
                stall_left = $urandom_range(0, rx_max_stall);
            end
            if (hold_ask) begin
                stall_left = HOLD_CYCLES;
                hold_ask = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any stretch without a handshake on either side is a hang.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_req(input logic [15:0] cu, input logic [7:0] at,
                                     input bit av, input logic [8:0] caret,
                                     input bit hu, input bit last_req);
        t_item req;
        req.code_unit  = cu;
        req.attr       = at;
        req.attr_valid = av;
        req.caret      = caret;
        req.has_unit   = hu;
        req.is_last    = last_req;
        pending_requests.push_back(req);
        queued_items++;
    endfunction

    // One composition of the given unit count, with a planted target run. Tidy
    // ones are valid UTF-16; the rest carry arbitrary units.
    task automatic queue_composition(input int units, input bit tidy);
        logic [15:0] cu_q[$];
        logic [8:0]  caret;
        logic [7:0]  at;
        int          run_from;
        int          run_len;
        int          k;
        int          pick;
        bit          tail_blank;
        tail_blank = units == 0 || $urandom_range(0, 9) == 0;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            caret = 9'($urandom_range(0, units + 1));
        else if (pick < 8)
            caret = 9'($urandom);
        else
            caret = 9'(units);
        while (cu_q.size() < units) begin
            if (tidy && $urandom_range(0, 3) == 0 && cu_q.size() + 2 <= units) begin
                cu_q.push_back(16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST)));
                cu_q.push_back(16'($urandom_range(LOW_SURR_FIRST, LOW_SURR_LAST)));
            end else if (tidy) begin
                if ($urandom_range(0, 1) == 0)
                    cu_q.push_back(16'($urandom_range(16'h0000, 16'hD7FF)));
                else
                    cu_q.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
            end else begin
                case ($urandom_range(0, 2))
                    0: cu_q.push_back(16'($urandom));
                    1: cu_q.push_back(16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST)));
                    default: cu_q.push_back(16'($urandom_range(LOW_SURR_FIRST,
                                                                LOW_SURR_LAST)));
                endcase
            end
        end
        run_from = $urandom_range(0, units);
        run_len = $urandom_range(1, 6);
        for (k = 0; k < units; k++) begin
            // occasional request with no unit, anywhere in the stream
            if ($urandom_range(0, 15) == 0)
                push_req(16'($urandom), 8'($urandom), 1'($urandom), 9'($urandom),
                         1'b0, 1'b0);
            if (k >= run_from && k < run_from + run_len)
                at = $urandom_range(0, 1) ? tgt_a : tgt_b;
            else if ($urandom_range(0, 4) == 0)
                at = tgt_a;
            else
                at = 8'($urandom);
            push_req(cu_q[k], at, $urandom_range(0, 9) != 0,
                     (k == 0) ? caret : 9'($urandom), 1'b1,
                     k == units - 1 && !tail_blank);
        end
        if (tail_blank)
            push_req(16'($urandom), 8'($urandom), 1'($urandom),
                     (units == 0) ? caret : 9'($urandom), 1'b0, 1'b1);
    endtask

    // Sender-side pause: everything queued is taken and answered, then the
    // pipeline is left to settle for requests that produce no result.
    task automatic wait_quiet();
        while (pending_requests.size() != 0 || holding_req || expected_mappings.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic set_targets(input logic [7:0] code_a, input logic [7:0] code_b);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TARGET_A;
        i_cfg_data <= code_a;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TARGET_B;
        i_cfg_data <= code_b;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tgt_a = code_a;
        tgt_b = code_b;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int p;
        int mark;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed compositions, reset target codes (1 and 3).
        // empty composition
        push_req(16'h0000, 8'h00, 1'b0, 9'd5, 1'b0, 1'b1);
        // caret on the low half of a pair; run closed by a non-target,
        // later target unit ignored
        push_req(16'hD800, 8'd1, 1'b1, 9'd1, 1'b1, 1'b0);
        push_req(16'hDC00, 8'd1, 1'b1, 9'd0, 1'b1, 1'b0);
        push_req(16'h0041, 8'd3, 1'b1, 9'd0, 1'b1, 1'b0);
        push_req(16'hDFFF, 8'd0, 1'b1, 9'd0, 1'b1, 1'b0);
        push_req(16'hFFFF, 8'd3, 1'b1, 9'd0, 1'b1, 1'b1);
        // caret re-latched by unit-less requests, missing attribute closes
        // the run, lone high in the middle, trailing high at the end
        push_req(16'h1234, 8'd1, 1'b1, 9'd7, 1'b0, 1'b0);
        push_req(16'h1234, 8'd1, 1'b1, 9'd2, 1'b0, 1'b0);
        push_req(16'h0000, 8'hFF, 1'b1, 9'd0, 1'b1, 1'b0);
        push_req(16'hDBFF, 8'd1, 1'b1, 9'd0, 1'b1, 1'b0);
        push_req(16'hD7FF, 8'd1, 1'b0, 9'd0, 1'b1, 1'b0);
        push_req(16'hE000, 8'd3, 1'b1, 9'd0, 1'b1, 1'b0);
        push_req(16'h5555, 8'd3, 1'b1, 9'd0, 1'b0, 1'b0);
        push_req(16'hDBFF, 8'd3, 1'b1, 9'd0, 1'b1, 1'b1);
        // caret far past the end
        push_req(16'hD83D, 8'd3, 1'b1, 9'h1FF, 1'b1, 1'b0);
        push_req(16'hDE00, 8'd3, 1'b1, 9'd0, 1'b1, 1'b0);
        push_req(16'hE000, 8'hFF, 1'b1, 9'd0, 1'b1, 1'b1);
        // caret exactly at the end
        push_req(16'h0030, 8'd3, 1'b1, 9'd2, 1'b1, 1'b0);
        push_req(16'h0031, 8'd1, 1'b1, 9'd0, 1'b1, 1'b1);
        // closing request carries no unit
        push_req(16'h0061, 8'd1, 1'b1, 9'd0, 1'b1, 1'b0);
        push_req(16'hAAAA, 8'd1, 1'b1, 9'd0, 1'b0, 1'b1);
        // single trailing high surrogate, caret 256
        push_req(16'hDABC, 8'd1, 1'b1, 9'd256, 1'b1, 1'b1);
        wait_quiet();

        // Receiver holds off while the sender streams closing requests back
        // to back, so the block has to stall its input.
        tx_max_gap = 0;
        hold_ask = 1'b1;
        for (p = 0; p < 20; p++)
            queue_composition(1, 1'b1);
        wait_quiet();

        // Random phases; each starts from a drained block with new targets.
        for (p = 0; p < 6; p++) begin
            case (p)
                0: set_targets(8'h00, 8'hFF);
                1: set_targets(8'hFF, 8'h00);
                2: set_targets(8'($urandom), 8'($urandom));
                3: set_targets(8'h55, 8'h55);
                4: set_targets(8'($urandom), 8'($urandom));
                default: set_targets(TARGET_A_RESET, TARGET_B_RESET);
            endcase
            tx_max_gap = (p == 1 || p == 3) ? 0 : 9;
            rx_max_stall = (p == 1 || p == 2) ? 0 : 9;
            mark = queued_items;
            // long compositions: overflow, exactly full, and around the limit
            if (p == 1)
                queue_composition(260, 1'b1);
            else if (p == 3)
                queue_composition(MAX_UNITS, 1'b1);
            else if (p == 5)
                queue_composition($urandom_range(250, 262), 1'b1);
            while (queued_items - mark < PHASE_ITEMS)
                queue_composition($urandom_range(0, 12), $urandom_range(0, 3) != 0);
            wait_quiet();
        end

        repeat (8) @(posedge i_clk);
        if (failures == 0 && expected_mappings.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/core/u16cim_pkg.sv
rtl/core/u16cim_in_reg.sv
rtl/core/u16cim_track.sv
rtl/core/u16cim_out_reg.sv
rtl/core/utf16_composition_index_mapper_unit.sv
rtl/core/u16cim_checker.sv
bench/tb_top.sv
